// ----- sv/planar_odometry_integrator_macros.svh -----
// Assertion macros shared by the odometry integrator RTL.
`ifndef PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_MACROS_SVH

// Property that must hold whenever the antecedent holds in the same cycle.
`define POI_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after the antecedent.
`define POI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/poi_pkg.sv -----
// Types, constants and helper functions of the planar odometry integrator.
package poi_pkg;

    // Field widths fixed by the interface.
    localparam int VEL_W   = 16;
    localparam int STEP_W  = 16;
    localparam int POS_W   = 48;
    localparam int HEAD_W  = 48;
    localparam int ANGLE_W = 32;

    // CORDIC datapath: Q30 vectors, angle residual in 2^-32 turns.
    localparam int CORD_W     = 34;
    localparam int TRIG_W     = 18;
    localparam int ATAN_IDX_W = 5;
    localparam logic signed [CORD_W-1:0] CORDIC_INV_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_MAX = 18'sd65536;

    // Shared multiplier operand and product widths.
    localparam int MUL_A_W = 35;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = 64;

    // Heading scale 2^38 / (2*pi*10^6) in Q16.
    localparam logic signed [MUL_B_W-1:0] HEAD_SCALE_Q16 = 33'sd2867080570;

    // Quadrant of the heading.
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    // Sine and cosine handed from the CORDIC unit to the sequencer.
    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_q16;
        logic signed [TRIG_W-1:0] sin_q16;
    } t_trig;

    // Sequencer states of the top level.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIG,
        ST_VYC,
        ST_VXS,
        ST_VYS,
        ST_VXC,
        ST_DX,
        ST_DY,
        ST_WS,
        ST_WK,
        ST_HD,
        ST_HA,
        ST_DONE
    } t_state;

    // Arctangent of 2^-i in 2^-32 turns.
    function automatic logic signed [ANGLE_W-1:0] f_atan(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'sd536870912;
            5'd1:    v = 32'sd316933406;
            5'd2:    v = 32'sd167458907;
            5'd3:    v = 32'sd85004756;
            5'd4:    v = 32'sd42667331;
            5'd5:    v = 32'sd21354465;
            5'd6:    v = 32'sd10679838;
            5'd7:    v = 32'sd5340245;
            5'd8:    v = 32'sd2670163;
            5'd9:    v = 32'sd1335087;
            5'd10:   v = 32'sd667544;
            5'd11:   v = 32'sd333772;
            5'd12:   v = 32'sd166886;
            5'd13:   v = 32'sd83443;
            5'd14:   v = 32'sd41722;
            5'd15:   v = 32'sd20861;
            5'd16:   v = 32'sd10430;
            5'd17:   v = 32'sd5215;
            5'd18:   v = 32'sd2608;
            5'd19:   v = 32'sd1304;
            5'd20:   v = 32'sd652;
            5'd21:   v = 32'sd326;
            5'd22:   v = 32'sd163;
            5'd23:   v = 32'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Divide by 2^16 with rounding half away from zero.
    function automatic logic signed [POS_W-1:0] f_round16(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] t;
        t = v + (v[PROD_W-1] ? 64'sd32767 : 64'sd32768);
        return t[PROD_W-1:16];
    endfunction

endpackage

// ----- sv/poi_mul.sv -----
// Shared signed multiplier with a registered product.
module poi_mul (
    input  logic                                i_clk,
    input  logic signed [poi_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [poi_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [poi_pkg::PROD_W-1:0]   o_p
);
    import poi_pkg::*;

    logic signed [MUL_A_W+MUL_B_W-1:0] w_full;
    logic signed [PROD_W-1:0]          r_p;

    // Every value the sequencer multiplies fits in the low product bits.
    assign w_full = i_a * i_b;

    always_ff @(posedge i_clk) begin
        r_p <= w_full[PROD_W-1:0];
    end

    assign o_p = r_p;

endmodule

// ----- sv/poi_cordic.sv -----
// Iterative CORDIC giving Q16 cosine and sine of a 32-bit binary angle.
`include "planar_odometry_integrator_macros.svh"

module poi_cordic #(
    parameter int TRIG_STEPS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [poi_pkg::ANGLE_W-1:0]   i_angle,
    output logic                          o_done,
    output poi_pkg::t_trig                o_trig
);
    import poi_pkg::*;

    localparam int CW = $clog2(TRIG_STEPS);

    logic                     r_busy;
    logic                     r_fin;
    logic                     r_done;
    logic [CW-1:0]            r_iter;
    t_quad                    r_quad;
    logic signed [CORD_W-1:0] r_x;
    logic signed [CORD_W-1:0] r_y;
    logic signed [CORD_W-1:0] r_z;
    t_trig                    r_trig;

    logic [ANGLE_W-1:0]       w_rnd;
    logic [1:0]               w_q;
    logic [ANGLE_W-1:0]       w_res;
    logic signed [CORD_W-1:0] w_sx;
    logic signed [CORD_W-1:0] w_sy;
    logic signed [CORD_W-1:0] w_at;
    logic signed [TRIG_W-1:0] w_xq;
    logic signed [TRIG_W-1:0] w_yq;
    logic                     w_last;

    // Round a Q30 value to Q16 and clamp it to plus or minus one.
    function automatic logic signed [TRIG_W-1:0] f_q16(input logic signed [CORD_W-1:0] v);
        logic signed [CORD_W-1:0] t;
        logic signed [TRIG_W-1:0] r;
        t = (v + 34'sd8192) >>> 14;
        if (t > CORD_W'(TRIG_MAX)) begin
            r = TRIG_MAX;
        end else if (t < -CORD_W'(TRIG_MAX)) begin
            r = -TRIG_MAX;
        end else begin
            r = t[TRIG_W-1:0];
        end
        return r;
    endfunction

    // Nearest quadrant and the residual angle inside it.
    assign w_rnd = i_angle + 32'h2000_0000;
    assign w_q   = w_rnd[ANGLE_W-1:ANGLE_W-2];
    assign w_res = i_angle - {w_q, {(ANGLE_W-2){1'b0}}};

    // Shared shifter and arctangent lookup for the current iteration.
    assign w_sx   = r_x >>> r_iter;
    assign w_sy   = r_y >>> r_iter;
    assign w_at   = CORD_W'(f_atan(ATAN_IDX_W'(r_iter)));
    assign w_last = (r_iter == CW'(TRIG_STEPS - 1));
    assign w_xq   = f_q16(r_x);
    assign w_yq   = f_q16(r_y);

    // Control: busy over the rotation steps, then r_fin and then r_done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= r_fin;
            r_fin  <= r_busy && w_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + CW'(1);
                if (w_last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: one micro-rotation per cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quad <= t_quad'(w_q);
            r_x    <= CORDIC_INV_GAIN;
            r_y    <= '0;
            r_z    <= CORD_W'(signed'(w_res));
        end else if (r_busy) begin
            if (!r_z[CORD_W-1]) begin
                r_x <= r_x - w_sy;
                r_y <= r_y + w_sx;
                r_z <= r_z - w_at;
            end else begin
                r_x <= r_x + w_sy;
                r_y <= r_y - w_sx;
                r_z <= r_z + w_at;
            end
        end
    end

    // Apply the quadrant by swapping and negating.
    always_ff @(posedge i_clk) begin
        if (r_fin) begin
            case (r_quad)
                QUAD_0: begin
                    r_trig.cos_q16 <= w_xq;
                    r_trig.sin_q16 <= w_yq;
                end
                QUAD_1: begin
                    r_trig.cos_q16 <= -w_yq;
                    r_trig.sin_q16 <= w_xq;
                end
                QUAD_2: begin
                    r_trig.cos_q16 <= -w_xq;
                    r_trig.sin_q16 <= -w_yq;
                end
                default: begin
                    r_trig.cos_q16 <= w_yq;
                    r_trig.sin_q16 <= -w_xq;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_trig = r_trig;

    `POI_ASSERT_NEXT(a_start_busy, i_start, r_busy, "CORDIC did not start")
    `POI_ASSERT_IMPLY(a_iter_range, r_busy, r_iter <= CW'(TRIG_STEPS - 1), "iteration overrun")
    `POI_ASSERT_NEXT(a_fin_done, r_fin, r_done && !r_busy, "finish did not raise done")

endmodule

// ----- sv/planar_odometry_integrator.sv -----
// Top level of the planar odometry integrator: sequencer, accumulators, ports.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one odometry tick per item:
//   body velocities i_vel_fwd, i_vel_side and yaw rate i_yaw_rate.
//   Output channel (o_out_valid / i_out_stall) returns one item per tick with
//   the updated position o_pos_x, o_pos_y and heading o_heading_angle.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the step time in
//   microseconds; it is always ready and should be written while idle.
//   One tick is in flight at a time: a new tick is accepted only once the
//   last one has left the sequencer for the output register. The iterative
//   CORDIC and the single shared multiplier, used for eight products in turn,
//   compute each tick one step after the other.
//   Reset clears both positions and the heading and sets the step to 1000 us.
//   A stalled result stays in the output register; the next tick may be
//   accepted and computed meanwhile and waits at the end for the register.
`include "planar_odometry_integrator_macros.svh"

module planar_odometry_integrator #(
    parameter int POSITION_BITS = 48,
    parameter int TRIG_STEPS    = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [poi_pkg::VEL_W-1:0]   i_vel_fwd,
    input  logic signed [poi_pkg::VEL_W-1:0]   i_vel_side,
    input  logic signed [poi_pkg::VEL_W-1:0]   i_yaw_rate,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [poi_pkg::STEP_W-1:0]         i_step_time_us,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [poi_pkg::POS_W-1:0]   o_pos_x,
    output logic signed [poi_pkg::POS_W-1:0]   o_pos_y,
    output logic [poi_pkg::ANGLE_W-1:0]        o_heading_angle
);
    import poi_pkg::*;

    localparam int SW = ((POSITION_BITS > POS_W) ? POSITION_BITS : POS_W) + 1;
    localparam logic signed [SW-1:0] SAT_HI = (SW'(1) <<< (POSITION_BITS - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

    t_state                          r_state;
    t_state                          n_state;
    logic [STEP_W-1:0]               r_step;
    logic signed [VEL_W-1:0]         r_vx;
    logic signed [VEL_W-1:0]         r_vy;
    logic signed [VEL_W-1:0]         r_w;
    logic signed [33:0]              r_t0;
    logic signed [MUL_A_W-1:0]       r_dxs;
    logic signed [MUL_A_W-1:0]       r_dys;
    logic signed [POS_W-1:0]         r_dr;
    logic signed [POSITION_BITS-1:0] r_x;
    logic signed [POSITION_BITS-1:0] r_y;
    logic [HEAD_W-1:0]               r_head;
    logic                            r_out_valid;
    logic signed [POS_W-1:0]         r_out_x;
    logic signed [POS_W-1:0]         r_out_y;
    logic [ANGLE_W-1:0]              r_out_h;

    logic                            w_accept;
    logic                            w_trig_done;
    t_trig                           w_trig;
    logic signed [MUL_A_W-1:0]       w_mul_a;
    logic signed [MUL_B_W-1:0]       w_mul_b;
    logic signed [PROD_W-1:0]        w_prod;
    logic signed [MUL_B_W-1:0]       w_st;
    logic signed [POSITION_BITS-1:0] w_acc;
    logic signed [SW-1:0]            w_sum;
    logic signed [POSITION_BITS-1:0] w_sat;
    logic                            w_out_free;

    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_st        = MUL_B_W'({1'b0, r_step});
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Sine and cosine of the heading before this tick.
    poi_cordic #(
        .TRIG_STEPS (TRIG_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_angle (r_head[HEAD_W-1:HEAD_W-ANGLE_W]),
        .o_done  (w_trig_done),
        .o_trig  (w_trig)
    );

    // The one multiplier, fed by the sequencer state.
    poi_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_prod)
    );

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            ST_VYC: begin
                w_mul_a = MUL_A_W'(r_vy);
                w_mul_b = MUL_B_W'(w_trig.cos_q16);
            end
            ST_VXS: begin
                w_mul_a = MUL_A_W'(r_vx);
                w_mul_b = MUL_B_W'(w_trig.sin_q16);
            end
            ST_VYS: begin
                w_mul_a = MUL_A_W'(r_vy);
                w_mul_b = MUL_B_W'(w_trig.sin_q16);
            end
            ST_VXC: begin
                w_mul_a = MUL_A_W'(r_vx);
                w_mul_b = MUL_B_W'(w_trig.cos_q16);
            end
            ST_DX: begin
                w_mul_a = r_dxs;
                w_mul_b = w_st;
            end
            ST_DY: begin
                w_mul_a = r_dys;
                w_mul_b = w_st;
            end
            ST_WS: begin
                w_mul_a = MUL_A_W'(r_w);
                w_mul_b = w_st;
            end
            ST_WK: begin
                w_mul_a = MUL_A_W'(signed'(w_prod[31:0]));
                w_mul_b = HEAD_SCALE_Q16;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Shared saturating adder: x in one step, y in the next.
    assign w_acc = (r_state == ST_WK) ? r_y : r_x;
    assign w_sum = SW'(w_acc) + SW'(r_dr);
    always_comb begin
        if (w_sum > SAT_HI) begin
            w_sat = SAT_HI[POSITION_BITS-1:0];
        end else if (w_sum < SAT_LO) begin
            w_sat = SAT_LO[POSITION_BITS-1:0];
        end else begin
            w_sat = w_sum[POSITION_BITS-1:0];
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_TRIG;
                end
            end
            ST_TRIG: begin
                if (w_trig_done) begin
                    n_state = ST_VYC;
                end
            end
            ST_VYC:  n_state = ST_VXS;
            ST_VXS:  n_state = ST_VYS;
            ST_VYS:  n_state = ST_VXC;
            ST_VXC:  n_state = ST_DX;
            ST_DX:   n_state = ST_DY;
            ST_DY:   n_state = ST_WS;
            ST_WS:   n_state = ST_WK;
            ST_WK:   n_state = ST_HD;
            ST_HD:   n_state = ST_HA;
            ST_HA:   n_state = ST_DONE;
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register and step configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_W'(1000);
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_step <= i_step_time_us;
            end
        end
    end

    // Accumulators and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x         <= '0;
            r_y         <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_WS:   r_x    <= w_sat;
                ST_WK:   r_y    <= w_sat;
                ST_HA:   r_head <= r_head + HEAD_W'(r_dr);
                default: ;
            endcase
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Partial sums, rounded deltas and the latched tick.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_vx <= i_vel_fwd;
            r_vy <= i_vel_side;
            r_w  <= i_yaw_rate;
        end
        case (r_state)
            ST_VXS: r_t0  <= w_prod[33:0];
            ST_VYS: r_dxs <= MUL_A_W'(r_t0) - MUL_A_W'(signed'(w_prod[33:0]));
            ST_VXC: r_t0  <= w_prod[33:0];
            ST_DX:  r_dys <= MUL_A_W'(r_t0) + MUL_A_W'(signed'(w_prod[33:0]));
            ST_DY:  r_dr  <= f_round16(w_prod);
            ST_WS:  r_dr  <= f_round16(w_prod);
            ST_HD:  r_dr  <= f_round16(w_prod);
            default: ;
        endcase
        if (r_state == ST_DONE && w_out_free) begin
            r_out_x <= POS_W'(r_x);
            r_out_y <= POS_W'(r_y);
            r_out_h <= r_head[HEAD_W-1:HEAD_W-ANGLE_W];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pos_x         = r_out_x;
    assign o_pos_y         = r_out_y;
    assign o_heading_angle = r_out_h;

    `POI_ASSERT_NEXT(a_accept_trig, w_accept, r_state == ST_TRIG, "tick did not start CORDIC")
    `POI_ASSERT_NEXT(a_head_hold, r_state != ST_HA, $stable(r_head), "heading moved off step")
    `POI_ASSERT_IMPLY(a_trig_wait, w_trig_done, r_state == ST_TRIG, "stray CORDIC done")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the planar odometry integrator.
`timescale 1ns / 1ps

module tb;
    import poi_pkg::*;

    localparam int     HOLD_CYCLES  = 300;
    localparam int     TAIL_CYCLES  = 40;
    localparam int     TRIG_ITER    = 16;
    localparam longint CYCLE_LIMIT  = 64'd6_000_000;
    localparam longint POS_MAX      = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint POS_MIN      = -POS_MAX - 64'sd1;
    localparam longint HALF_TURN    = 64'sh0000_8000_0000_0000;
    localparam longint FULL_TURN    = 64'sh0001_0000_0000_0000;
    localparam longint HEAD_GAIN    = 64'sd2867080570;
    // Heading advance per unit of yaw rate at the longest step, in 2^-48 turn.
    localparam longint YAW_UNIT_MAX = 64'sd2867036822;

    // One expected result item.
    typedef struct {
        logic [47:0] pos_x;
        logic [47:0] pos_y;
        logic [31:0] heading_angle;
    } pose_t;

    // Tracks the pose the block should reach and compares every result item.
    class odometry_scoreboard;
        longint      x_pos;
        longint      y_pos;
        bit [47:0]   heading;
        bit [15:0]   step_us;
        longint      arctan_turns[TRIG_ITER];
        pose_t       expected_q[$];
        int unsigned mismatches;

        function new();
            x_pos = 0;
            y_pos = 0;
            heading = '0;
            step_us = 16'd1000;
            mismatches = 0;
            arctan_turns = '{536870912, 316933406, 167458907, 85004756, 42667331,
                             21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                             333772, 166886, 83443, 41722, 20861};
        endfunction

        function void set_step(bit [15:0] v);
            step_us = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Q30 vector component to Q16 with rounding and clamping.
        function longint q30_to_q16(longint v);
            longint r;
            r = (v + 64'sd8192) >>> 14;
            if (r > 64'sd65536) r = 64'sd65536;
            if (r < -64'sd65536) r = -64'sd65536;
            return r;
        endfunction

        // Divide by 2^16 rounding half away from zero.
        function longint div_round16(longint v);
            if (v >= 0) return (v + 64'sd32768) >>> 16;
            return -((-v + 64'sd32768) >>> 16);
        endfunction

        function longint sat_add(longint acc, longint d);
            if (d > 0 && acc > POS_MAX - d) return POS_MAX;
            if (d < 0 && acc < POS_MIN - d) return POS_MIN;
            return acc + d;
        endfunction

        // Cosine and sine of a 32-bit binary angle, nearest quadrant plus CORDIC residual.
        function void heading_trig(bit [31:0] ang, output longint c, output longint s);
            bit [31:0] shifted;
            bit [31:0] resid;
            t_quad     quad;
            longint    xv;
            longint    yv;
            longint    z;
            longint    t;
            shifted = ang + 32'h2000_0000;
            quad = t_quad'(shifted[31:30]);
            resid = ang - {shifted[31:30], 30'd0};
            z = longint'($signed(resid));
            xv = 64'sd652032874;
            yv = 0;
            for (int i = 0; i < TRIG_ITER; i++) begin
                if (z >= 0) begin
                    t = xv - (yv >>> i);
                    yv = yv + (xv >>> i);
                    z = z - arctan_turns[i];
                end else begin
                    t = xv + (yv >>> i);
                    yv = yv - (xv >>> i);
                    z = z + arctan_turns[i];
                end
                xv = t;
            end
            xv = q30_to_q16(xv);
            yv = q30_to_q16(yv);
            case (quad)
                QUAD_0: begin
                    c = xv;
                    s = yv;
                end
                QUAD_1: begin
                    c = -yv;
                    s = xv;
                end
                QUAD_2: begin
                    c = -xv;
                    s = -yv;
                end
                default: begin
                    c = yv;
                    s = -xv;
                end
            endcase
        endfunction

        // Advance the pose by one accepted tick and queue the expected item.
        function void note_tick(logic signed [15:0] fwd, logic signed [15:0] side,
                                logic signed [15:0] yaw);
            longint c;
            longint s;
            longint vx;
            longint vy;
            longint w;
            longint st;
            longint dh;
            pose_t  p;
            heading_trig(heading[47:16], c, s);
            vx = fwd;
            vy = side;
            w = yaw;
            st = longint'(step_us);
            x_pos = sat_add(x_pos, div_round16((vy * c - vx * s) * st));
            y_pos = sat_add(y_pos, div_round16((vy * s + vx * c) * st));
            dh = div_round16((w * st) * HEAD_GAIN);
            heading = heading + dh[47:0];
            p.pos_x = x_pos[47:0];
            p.pos_y = y_pos[47:0];
            p.heading_angle = heading[47:16];
            expected_q.push_back(p);
        endfunction

        // Compare one result item with the oldest expectation.
        function void check_pose(logic [47:0] px, logic [47:0] py, logic [31:0] ang);
            pose_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result item: pos_x %h pos_y %h heading %h",
                         $time, px, py, ang);
                mismatches++;
                return;
            end
            e = expected_q.pop_front();
            if (px !== e.pos_x) begin
                $display("%0t: pos_x expected %h, got %h", $time, e.pos_x, px);
                mismatches++;
            end
            if (py !== e.pos_y) begin
                $display("%0t: pos_y expected %h, got %h", $time, e.pos_y, py);
                mismatches++;
            end
            if (ang !== e.heading_angle) begin
                $display("%0t: heading_angle expected %h, got %h",
                         $time, e.heading_angle, ang);
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic signed [VEL_W-1:0]   i_vel_fwd = '0;
    logic signed [VEL_W-1:0]   i_vel_side = '0;
    logic signed [VEL_W-1:0]   i_yaw_rate = '0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [STEP_W-1:0]         i_step_time_us = 16'd1000;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic signed [POS_W-1:0]   o_pos_x;
    logic signed [POS_W-1:0]   o_pos_y;
    logic [ANGLE_W-1:0]        o_heading_angle;

    odometry_scoreboard sb = new();

    longint      cycle_count = 0;
    int unsigned burst_left = 0;
    int unsigned seg_left = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;
    logic [7:0]  hold_ticket = '0;
    logic [7:0]  hold_served = '0;
    logic        rx_quiet = 1'b0;

    planar_odometry_integrator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_vel_fwd       (i_vel_fwd),
        .i_vel_side      (i_vel_side),
        .i_yaw_rate      (i_yaw_rate),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_step_time_us  (i_step_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading_angle (o_heading_angle)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: run did not complete within %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver: long hold-offs on request, no stalls while quiet, otherwise segments of varying stall density.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (rx_quiet) begin
            i_out_stall <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left <= $urandom_range(20, 200);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct <= 0;
                    2:       stall_pct <= 25;
                    3:       stall_pct <= 50;
                    default: stall_pct <= 90;
                endcase
            end else begin
                seg_left <= seg_left - 1;
            end
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Observe every handshake on the three channels.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_step(i_step_time_us);
            if (i_in_valid && !o_in_stall) sb.note_tick(i_vel_fwd, i_vel_side, i_yaw_rate);
            if (o_out_valid && !i_out_stall) sb.check_pose(o_pos_x, o_pos_y, o_heading_angle);
        end
    end

    // Offer one tick item and return at the edge that accepts it.
    task automatic send_tick(input logic signed [15:0] fwd, input logic signed [15:0] side,
                             input logic signed [15:0] yaw, input bit paced);
        int unsigned gap;
        if (paced) begin
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 30);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_vel_fwd <= fwd;
        i_vel_side <= side;
        i_yaw_rate <= yaw;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop offering and wait until every expected item has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
        @(posedge i_clk);
    endtask

    task automatic write_step(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_step_time_us <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_vel();
        logic signed [15:0] r;
        case ($urandom_range(0, 11))
            0:       r = 16'sh7FFF;
            1:       r = 16'sh8000;
            2: begin
                r = 16'($urandom_range(0, 128));
                r = r - 16'sd64;
            end
            default: r = 16'($urandom);
        endcase
        return r;
    endfunction

    initial begin
        logic signed [31:0] ang_err;
        logic [15:0]        step_val;
        longint             head_off;
        longint             yaw_cmd;
        int unsigned        n_items;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Field extremes and bit patterns at the reset step of 1000 us.
        send_tick(16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_tick(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_tick(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_tick(16'sh7FFF, 16'sh8000, 16'sd0, 1'b0);
        send_tick(16'sh8000, 16'sh7FFF, -16'sd1, 1'b0);
        send_tick(16'sh5555, 16'shAAAA, 16'sh5555, 1'b0);
        send_tick(16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0);
        send_tick(16'sd1, -16'sd1, 16'sd1, 1'b0);
        drain_results();

        // Longest step: a full yaw rate turns a third of a circle per item, so
        // the heading sweeps every quadrant and wraps both ways.
        write_step(16'hFFFF);
        repeat (4) send_tick(16'sh7FFF, 16'sd0, 16'sh7FFF, 1'b0);
        repeat (3) send_tick(16'sd0, 16'sh8000, 16'sh8000, 1'b0);
        send_tick(16'sh8000, 16'sh7FFF, 16'sd12345, 1'b0);
        drain_results();

        // A zero step leaves the state untouched.
        write_step(16'h0000);
        send_tick(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
        send_tick(16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0);
        drain_results();

        write_step(16'h0001);
        send_tick(16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0);
        send_tick(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
        send_tick(16'sd1, 16'sd1, 16'sd1, 1'b0);
        drain_results();

        // Steer the heading close to zero, then drive hard along both axes.
        rx_quiet <= 1'b1;
        write_step(16'hFFFF);
        ang_err = sb.heading[47:16];
        while (ang_err > 32'sd1048576 || ang_err < -32'sd1048576) begin
            head_off = longint'(sb.heading);
            if (head_off >= HALF_TURN) head_off = head_off - FULL_TURN;
            yaw_cmd = -head_off / YAW_UNIT_MAX;
            if (yaw_cmd > 64'sd32767) yaw_cmd = 64'sd32767;
            if (yaw_cmd < -64'sd32767) yaw_cmd = -64'sd32767;
            send_tick(16'sd0, 16'sd0, yaw_cmd[15:0], 1'b0);
            drain_results();
            ang_err = sb.heading[47:16];
        end
        // Push x up and y down at full speed, then reverse.
        repeat (3) send_tick(16'sh8000, 16'sh7FFF, 16'sd0, 1'b0);
        repeat (3) send_tick(16'sh7FFF, 16'sh8000, 16'sd0, 1'b0);
        drain_results();
        rx_quiet <= 1'b0;

        // Random phases, each under its own step setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                1:       step_val = 16'hFFFF;
                2:       step_val = 16'h0001;
                3:       step_val = 16'($urandom_range(1, 255));
                4:       step_val = 16'h0000;
                default: step_val = 16'($urandom_range(1, 65535));
            endcase
            write_step(step_val);
            n_items = (ph == 4) ? 40 : 200;
            // In the long-step phase the receiver holds off while items keep coming.
            if (ph == 1) hold_ticket <= hold_ticket + 8'd1;
            for (int k = 0; k < n_items; k++) begin
                send_tick(rand_vel(), rand_vel(), rand_vel(), ph != 1);
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
